### hw/rtl/smcc_pkg.sv
// Package for the sensor matrix crosstalk compensator: word types and fixed constants.
`timescale 1ns / 1ps
`default_nettype none

package smcc_pkg;

  // Fixed field widths
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned VALUE_W  = 10;
  // Compensated result is below 256, so the divider yields eight quotient bits
  localparam int unsigned QUOT_W   = 8;
  localparam int unsigned STEP_W   = 3;
  // Numerator 255*v fits in sample width plus quotient width
  localparam int unsigned NUM_W    = SAMPLE_W + QUOT_W;

  // Input word: one ADC reading
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                frame_end;
  } smcc_in_t;

  // Output word: one scaled cell
  typedef struct packed {
    logic [VALUE_W-1:0] cell_value;
    logic               last_cell;
  } smcc_out_t;

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } smcc_div_stat_t;

endpackage

`default_nettype wire

### hw/rtl/smcc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module smcc_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/smcc_div.sv
// Shared iterative restoring divider, one quotient bit per cycle, quotient below 256.
`timescale 1ns / 1ps
`default_nettype none

module smcc_div
  import smcc_pkg::*;
#(
  parameter int unsigned DEN_W = 13
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [NUM_W-1:0]  dividend_i,
  input  wire logic [DEN_W-1:0]  divisor_i,
  output logic      [QUOT_W-1:0] quotient_o,
  output smcc_div_stat_t         stat_o
);

  localparam int unsigned SH_W  = DEN_W + QUOT_W - 1;
  localparam int unsigned CMP_W = (SH_W > NUM_W) ? SH_W : NUM_W;

  logic [CMP_W-1:0]  rem_q, rem_d;
  logic [CMP_W-1:0]  dsh_q, dsh_d;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              fits;

  // Trial subtract of the shifted divisor
  assign fits = (rem_q >= dsh_q);

  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = CMP_W'(dividend_i);
      dsh_d  = CMP_W'(divisor_i) << (QUOT_W - 1);
      quot_d = '0;
      step_d = STEP_W'(QUOT_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = rem_q - dsh_q;
      end
      quot_d = {quot_q[QUOT_W-2:0], fits};
      dsh_d  = dsh_q >> 1;
      step_d = step_q - STEP_W'(1);
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign quotient_o  = quot_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

### hw/rtl/sensor_matrix_crosstalk_comp_core.sv
// Top level of the sensor matrix crosstalk compensator: frame load, column sums, sequencer.
//
//  Channel  Direction  Handshake              Word
//  in       input      in_valid_i/in_ready_o  smcc_in_t  {sample, frame_end}
//  out      output     out_valid_o/out_ready_i smcc_out_t {cell_value, last_cell}
//  cfg      input      cfg_valid_i/cfg_ready_o compensate_enable, always ready
//
//  Samples load at one word per cycle until the frame completes.
//  Each compensated cell then goes through read, set-up, 8 divider steps, done and
//  hand-off; a plain or zero cell goes only through read, set-up and hand-off.
//  Input is not ready while a frame is being emitted; output stalls hold the
//  sequencer in its hand-off state. Reset clears column sums and positions at once.
`timescale 1ns / 1ps
`default_nettype none

module sensor_matrix_crosstalk_comp_core
  import smcc_pkg::*;
#(
  parameter int unsigned ROWS       = 4,
  parameter int unsigned COLS       = 4,
  parameter int unsigned FULL_SCALE = 4095
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire smcc_in_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output smcc_out_t     out_data_o,
  input  wire logic     cfg_valid_i,
  output logic          cfg_ready_o,
  input  wire logic     cfg_compensate_enable_i
);

  localparam int unsigned CELLS = ROWS * COLS;
  localparam int unsigned IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned COL_W = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int unsigned CS_W  = $clog2(FULL_SCALE + 1);
  localparam int unsigned SUM_W = ((CS_W > SAMPLE_W) ? CS_W : SAMPLE_W) + 1;

  // Sequencer codes
  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_CALC = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [IDX_W-1:0]    pos_q, pos_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [IDX_W-1:0]    rd_idx_q, rd_idx_d;
  logic [COL_W-1:0]    rd_col_q, rd_col_d;
  logic [IDX_W-1:0]    last_idx_q, last_idx_d;
  logic                cfg_q;
  logic                comp_q, comp_d;
  logic [CS_W-1:0]     colsum_q [COLS];
  logic [VALUE_W-1:0]  res_q, res_d;
  logic                out_valid_q, out_valid_d;
  smcc_out_t           out_q, out_d;

  logic                in_fire;
  logic                frame_done;
  logic                cs_we;
  logic                cs_clr;
  logic [COL_W-1:0]    cs_idx;
  logic [CS_W-1:0]     cs_rd;
  logic [SUM_W-1:0]    cs_sum;
  logic [CS_W-1:0]     cs_new;
  logic [SAMPLE_W-1:0] cell_v;
  logic                div_start;
  logic [NUM_W-1:0]    div_num;
  logic [SUM_W-1:0]    div_den;
  logic [QUOT_W-1:0]   div_quot;
  smcc_div_stat_t      div_stat;
  logic                out_free;
  logic                is_last;

  // Frame store
  smcc_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (CELLS)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire),
    .waddr_i (pos_q),
    .wdata_i (in_data_i.sample),
    .raddr_i (rd_idx_q),
    .rdata_o (cell_v)
  );

  // Shared divider
  smcc_div #(
    .DEN_W (SUM_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .quotient_o (div_quot),
    .stat_o     (div_stat)
  );

  assign in_ready_o  = (state_q == ST_LOAD);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign frame_done  = in_data_i.frame_end || (pos_q == IDX_W'(CELLS - 1));
  assign out_free    = !out_valid_q || out_ready_i;
  assign is_last     = (rd_idx_q == last_idx_q);

  // Column sum read: load column while loading, emitted column otherwise
  assign cs_idx = (state_q == ST_LOAD) ? col_q : rd_col_q;
  assign cs_rd  = colsum_q[cs_idx];
  assign cs_sum = SUM_W'(cs_rd) + SUM_W'(in_data_i.sample);
  assign cs_new = (cs_sum > SUM_W'(FULL_SCALE)) ? CS_W'(FULL_SCALE) : cs_sum[CS_W-1:0];

  // Compensation operands: 255*v and FULL_SCALE - (colsum - v)
  assign div_num = (NUM_W'(cell_v) << QUOT_W) - NUM_W'(cell_v);
  assign div_den = SUM_W'(FULL_SCALE) + SUM_W'(cell_v) - SUM_W'(cs_rd);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    col_d       = col_q;
    rd_idx_d    = rd_idx_q;
    rd_col_d    = rd_col_q;
    last_idx_d  = last_idx_q;
    comp_d      = comp_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    cs_we       = 1'b0;
    cs_clr      = 1'b0;
    div_start   = 1'b0;
    case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          cs_we = 1'b1;
          if (frame_done) begin
            last_idx_d = pos_q;
            comp_d     = cfg_q;
            rd_idx_d   = '0;
            rd_col_d   = '0;
            state_d    = ST_READ;
          end else begin
            pos_d = pos_q + IDX_W'(1);
            col_d = (col_q == COL_W'(COLS - 1)) ? '0 : col_q + COL_W'(1);
          end
        end
      end
      ST_READ: begin
        state_d = ST_CALC;
      end
      ST_CALC: begin
        if (cell_v == '0) begin
          res_d   = '0;
          state_d = ST_OUT;
        end else if (!comp_q) begin
          res_d   = cell_v[SAMPLE_W-1:2];
          state_d = ST_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          res_d   = VALUE_W'(div_quot);
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.cell_value    = res_q;
          out_d.last_cell     = is_last;
          if (is_last) begin
            cs_clr  = 1'b1;
            pos_d   = '0;
            col_d   = '0;
            state_d = ST_LOAD;
          end else begin
            rd_idx_d = rd_idx_q + IDX_W'(1);
            rd_col_d = (rd_col_q == COL_W'(COLS - 1)) ? '0 : rd_col_q + COL_W'(1);
            state_d  = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      pos_q       <= '0;
      col_q       <= '0;
      rd_idx_q    <= '0;
      rd_col_q    <= '0;
      last_idx_q  <= '0;
      comp_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      col_q       <= col_d;
      rd_idx_q    <= rd_idx_d;
      rd_col_q    <= rd_col_d;
      last_idx_q  <= last_idx_d;
      comp_q      <= comp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_q <= cfg_compensate_enable_i;
    end
  end

  // Saturating column sums, cleared after each frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < COLS; c++) begin
        colsum_q[c] <= '0;
      end
    end else if (cs_clr) begin
      for (int c = 0; c < COLS; c++) begin
        colsum_q[c] <= '0;
      end
    end else if (cs_we) begin
      colsum_q[col_q] <= cs_new;
    end
  end

  // Result and output word
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### hw/rtl/smcc_checker.sv
// Port-level checker for the crosstalk compensator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module smcc_checker
  import smcc_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire smcc_in_t  in_data_i,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire smcc_out_t out_data_o,
  input wire logic      cfg_valid_i,
  input wire logic      cfg_ready_o,
  input wire logic      cfg_compensate_enable_i
);

  // A stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // No input is taken while a frame still has cells to emit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_cell |-> !in_ready_o)
    else $error("input ready in the middle of a frame");

  // A marked sample closes the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.frame_end |=> !in_ready_o)
    else $error("input still ready after frame end");

  // A new result only appears from the emit phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared during frame load");

  // Register writes are always taken, with a known value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o && !$isunknown(cfg_compensate_enable_i))
    else $error("register write refused or unknown");

endmodule

bind sensor_matrix_crosstalk_comp_core smcc_checker u_smcc_checker (
  .clk_i                   (clk_i),
  .rst_ni                  (rst_ni),
  .in_valid_i              (in_valid_i),
  .in_ready_o              (in_ready_o),
  .in_data_i               (in_data_i),
  .out_valid_o             (out_valid_o),
  .out_ready_i             (out_ready_i),
  .out_data_o              (out_data_o),
  .cfg_valid_i             (cfg_valid_i),
  .cfg_ready_o             (cfg_ready_o),
  .cfg_compensate_enable_i (cfg_compensate_enable_i)
);

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for the sensor matrix crosstalk compensator core.
`timescale 1ns / 1ps

module tb;
  import smcc_pkg::*;

  localparam int unsigned ROWS       = 4;
  localparam int unsigned COLS       = 4;
  localparam int unsigned FULL_SCALE = 4095;
  localparam int unsigned CELLS      = ROWS * COLS;
  localparam int unsigned SETTLE     = 40;
  localparam int unsigned MAX_NOTES  = 10;
  localparam logic        COMP_OFF   = 1'b0;
  localparam logic        COMP_ON    = 1'b1;

  logic      clk_i;
  logic      rst_n       = 1'b0;
  logic      in_valid    = 1'b0;
  smcc_in_t  in_word     = '0;
  logic      out_ready   = 1'b1;
  logic      cfg_valid   = 1'b0;
  logic      cfg_comp    = COMP_ON;
  logic      in_ready;
  logic      out_valid;
  smcc_out_t out_word;
  logic      cfg_ready;

  // Idling on both sides; switched off for the closing part of the run
  bit idle_on = 1'b1;
  int unsigned err_count = 0;

  // Predictor state: stored frame, saturating column totals, load index, mode
  logic [SAMPLE_W-1:0] frame_cells [CELLS];
  logic [SAMPLE_W-1:0] column_total [COLS] = '{default: '0};
  int unsigned         load_index = 0;
  logic                comp_on    = COMP_ON;
  smcc_out_t           expected_cells [$];

  sensor_matrix_crosstalk_comp_core #(
    .ROWS      (ROWS),
    .COLS      (COLS),
    .FULL_SCALE(FULL_SCALE)
  ) dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_n),
    .in_valid_i             (in_valid),
    .in_ready_o             (in_ready),
    .in_data_i              (in_word),
    .out_valid_o            (out_valid),
    .out_ready_i            (out_ready),
    .out_data_o             (out_word),
    .cfg_valid_i            (cfg_valid),
    .cfg_ready_o            (cfg_ready),
    .cfg_compensate_enable_i(cfg_comp)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Scaled value of one cell given its column total
  function automatic logic [VALUE_W-1:0] scaled_cell(logic [SAMPLE_W-1:0] v,
                                                     logic [SAMPLE_W-1:0] colsum);
    int unsigned divisor;
    if (v == '0) return '0;
    if (comp_on == COMP_OFF) return VALUE_W'(v / 4);
    // Saturated totals keep the divisor at v or above
    divisor = FULL_SCALE + int'(v) - int'(colsum);
    return VALUE_W'((255 * int'(v)) / divisor);
  endfunction

  // Load one sample; on frame completion queue one result per loaded cell
  function automatic void load_cell(logic [SAMPLE_W-1:0] v, logic mark);
    int unsigned pos;
    int unsigned col;
    int unsigned sum;
    smcc_out_t   res_word;
    pos = (load_index >= CELLS) ? 0 : load_index;
    frame_cells[pos] = v;
    col = pos % COLS;
    sum = int'(column_total[col]) + int'(v);
    if (sum > FULL_SCALE) sum = FULL_SCALE;
    column_total[col] = SAMPLE_W'(sum);
    if (!mark && pos + 1 < CELLS) begin
      load_index = pos + 1;
      return;
    end
    for (int unsigned k = 0; k <= pos; k++) begin
      res_word.cell_value = scaled_cell(frame_cells[k], column_total[k % COLS]);
      res_word.last_cell  = (k == pos);
      expected_cells.push_back(res_word);
    end
    foreach (column_total[c]) column_total[c] = '0;
    load_index = 0;
  endfunction

  task automatic note_failure(input string msg);
    err_count++;
    if (err_count <= MAX_NOTES) $display("%0t: %s", $realtime, msg);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    smcc_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_cells.size() == 0) begin
        note_failure($sformatf("unexpected cell value=%0d last=%0b",
                               out_word.cell_value, out_word.last_cell));
      end else begin
        want = expected_cells.pop_front();
        if (out_word.cell_value !== want.cell_value)
          note_failure($sformatf("cell_value expected %0d got %0d",
                                 want.cell_value, out_word.cell_value));
        if (out_word.last_cell !== want.last_cell)
          note_failure($sformatf("last_cell expected %0b got %0b",
                                 want.last_cell, out_word.last_cell));
      end
    end
  end

  // Receiver stalls: random bursts between ready stretches of varying length
  initial begin
    forever begin
      repeat ($urandom_range(1, 30)) @(negedge clk_i);
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
        out_ready <= 1'b1;
      end
    end
  end

  // Send one word; called and returning at a falling edge, valid left high
  task automatic send_sample(input logic [SAMPLE_W-1:0] v, input logic mark);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= '{sample: v, frame_end: mark};
    do @(posedge clk_i); while (!in_ready);
    load_cell(v, mark);
    @(negedge clk_i);
  endtask

  // Drop valid and hold off until every queued result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (expected_cells.size() != 0);
  endtask

  task automatic set_compensation(input logic mode);
    wait_drained();
    repeat (SETTLE) @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_comp  <= mode;
    do @(posedge clk_i); while (!cfg_ready);
    comp_on = mode;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return SAMPLE_W'($urandom_range(0, 63));
      3:       return SAMPLE_W'($urandom_range(3000, 4095));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Single cell frame at full scale
  task automatic test_single_cell();
    send_sample('1, 1'b1);
  endtask

  // Frame ended early, with a zero sample and the extremes
  task automatic test_early_end();
    send_sample('0, 1'b0);
    send_sample('1, 1'b0);
    send_sample(12'd1, 1'b1);
  endtask

  // Full matrix with no end mark; column totals saturate
  task automatic test_full_matrix_no_mark();
    for (int unsigned k = 0; k < CELLS; k++)
      send_sample((k == 5) ? 12'd0 : (k == 10) ? 12'd1 : 12'hFFF, 1'b0);
  endtask

  // Plain divide by four
  task automatic test_plain_scaling();
    set_compensation(COMP_OFF);
    send_sample('1, 1'b0);
    send_sample(12'd4, 1'b0);
    send_sample(12'd3, 1'b1);
    set_compensation(COMP_ON);
  endtask

  // Random frames: mostly marked short frames, some full with or without mark
  task automatic test_random_frames(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned shape;
    sent = 0;
    while (sent < n_items) begin
      shape = $urandom_range(0, 19);
      len   = (shape < 14) ? $urandom_range(1, CELLS) : CELLS;
      for (int unsigned k = 0; k < len; k++)
        send_sample(pick_sample(), (k + 1 == len) && (shape < 17));
      sent += len;
      // Occasional hold-off until the output side is empty
      if ($urandom_range(0, 15) == 0) wait_drained();
    end
  endtask

  // Main sequence
  initial begin
    repeat (8) @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    test_single_cell();
    test_early_end();
    test_full_matrix_no_mark();
    test_plain_scaling();

    test_random_frames(160);
    wait_drained();
    set_compensation(COMP_OFF);
    test_random_frames(120);
    set_compensation(COMP_ON);
    test_random_frames(120);
    set_compensation(logic'($urandom_range(0, 1)));
    idle_on = 1'b0;
    test_random_frames(80);

    wait_drained();
    repeat (SETTLE) @(negedge clk_i);
    if (expected_cells.size() != 0)
      note_failure($sformatf("%0d cells never emitted", expected_cells.size()));
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/smcc_pkg.sv
hw/rtl/smcc_ram.sv
hw/rtl/smcc_div.sv
hw/rtl/sensor_matrix_crosstalk_comp_core.sv
hw/rtl/smcc_checker.sv
tb/sv/tb.sv
